>>> rtl/etg_pkg.sv
// Shared types and codes for the edge trigger interpolator.
`default_nettype none

package etg_pkg;

    // Fraction format: unsigned Q0.16 with one extra bit so that 1.0 fits.
    localparam int FRAC_BITS = 16;
    localparam int FRAC_W    = FRAC_BITS + 1;
    localparam int STEP_W    = $clog2(FRAC_W);

    // Edge kind codes as reported in the result.
    localparam logic [1:0] KIND_FLAT = 2'd0;
    localparam logic [1:0] KIND_RISE = 2'd1;
    localparam logic [1:0] KIND_FALL = 2'd2;

    // Edge mode codes of the trigger configuration.
    localparam logic [1:0] MODE_ANY  = 2'd0;
    localparam logic [1:0] MODE_RISE = 2'd1;
    localparam logic [1:0] MODE_FALL = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_TRIGGER_LEVEL  = 2'd0;
    localparam logic [1:0] REG_EDGE_MODE      = 2'd1;
    localparam logic [1:0] REG_CHANNEL_SELECT = 2'd2;

    // Control states of the top level, one-hot.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } etg_state_t;

    // Status of the serial divider as seen by the controller.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

>>> rtl/etg_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module etg_div
    import etg_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [SAMPLE_BITS-1:0] num,
    input  wire logic [SAMPLE_BITS-1:0] den,
    output logic      [FRAC_W-1:0]      quot,
    output div_status_t                 status
);

    logic [SAMPLE_BITS:0]   rem_reg,  rem_next;
    logic [SAMPLE_BITS-1:0] den_reg,  den_next;
    logic [FRAC_W-1:0]      quot_reg, quot_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;

    logic [SAMPLE_BITS+1:0] trial;
    logic                   ge;
    logic [SAMPLE_BITS:0]   kept;

    // One trial subtraction per cycle; the partial remainder stays below the divisor.
    always_comb
    begin
        trial = {1'b0, rem_reg} - {2'b00, den_reg};
        ge    = ~trial[SAMPLE_BITS+1];
        kept  = ge ? trial[SAMPLE_BITS:0] : rem_reg;
    end

    // Load on start, then shift one quotient bit in per step.
    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = {1'b0, num};
            den_next  = den;
            quot_next = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = {kept[SAMPLE_BITS-1:0], 1'b0};
            quot_next = {quot_reg[FRAC_W-2:0], ge};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(FRAC_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control bits get reset; the datapath registers do not need it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign quot        = quot_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

>>> rtl/edge_trigger_interpolator.sv
// Top level of the edge trigger with linear interpolation of the crossing point.
//
// Usage:
//   The slave stream carries one sample row per beat: tdata holds the channel
//   samples, channel 0 in the lowest bits, and tuser bit 0 is frame_start.
//   The block watches the channel picked by channel_select and pairs each
//   sample with the previous one of the same frame. When the trigger level
//   lies inside a pair and the edge matches edge_mode, one result beat goes
//   out on the master stream: tdata holds crossing_index then
//   crossing_fraction (Q0.16, 65536 is 1.0), tuser holds edge_kind.
// Timing:
//   A row with no result keeps s_tready high. A flat crossing drops
//   s_tready until it has moved to the output register.
//   A sloped crossing runs the serial divider, one quotient bit per cycle, then
//   passes ST_DONE to the output register; its result beat appears when
//   s_tready returns high, and no row is taken in between.
// Reset and stalls:
//   Reset clears the configuration, the frame state and the output valid flag.
//   A result waits in the output register while m_tready is low; the next
//   row is still taken, and only a further result has to wait for it.
`default_nettype none

module edge_trigger_interpolator
    import etg_pkg::*;
#(
    parameter int CHANNELS    = 4,
    parameter int SAMPLE_BITS = 16,
    parameter int INDEX_BITS  = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // Configuration write port.
    input  wire logic                     cfg_wen,
    input  wire logic [1:0]               cfg_index,
    input  wire logic [SAMPLE_BITS-1:0]   cfg_data,
    // Slave stream: sample rows.
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    // s_tdata from bit 0 up: sample_ch0 .. sample_chN, then zero padding.
    input  wire logic [((CHANNELS*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    // s_tuser: bit 0 frame_start.
    input  wire logic [0:0]               s_tuser,
    // Master stream: crossings.
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    // m_tdata from bit 0 up: crossing_index, crossing_fraction, zero padding.
    output logic [((INDEX_BITS+FRAC_W+7)/8)*8-1:0] m_tdata,
    // m_tuser: edge_kind.
    output logic [1:0]                    m_tuser
);

    localparam int OUT_W    = ((INDEX_BITS + FRAC_W + 7) / 8) * 8;
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [3:0] LAST_CH = 4'(CHANNELS - 1);
    localparam logic [INDEX_BITS-1:0] INDEX_MAX = '1;

    // Configuration registers.
    logic signed [SAMPLE_BITS-1:0] trigger_level_reg;
    logic [1:0]                    edge_mode_reg;
    logic [1:0]                    channel_select_reg;

    // Frame state.
    logic signed [SAMPLE_BITS-1:0] prev_sample_reg, prev_sample_next;
    logic                          have_prev_reg,   have_prev_next;
    logic [INDEX_BITS-1:0]         row_count_reg,   row_count_next;

    // Pending result and control.
    etg_state_t                    state_reg, state_next;
    logic [INDEX_BITS-1:0]         pend_index_reg, pend_index_next;
    logic [1:0]                    pend_kind_reg,  pend_kind_next;
    logic                          pend_flat_reg,  pend_flat_next;

    // Output register.
    logic                          out_valid_reg, out_valid_next;
    logic [INDEX_BITS-1:0]         out_index_reg, out_index_next;
    logic [FRAC_W-1:0]             out_frac_reg,  out_frac_next;
    logic [1:0]                    out_kind_reg,  out_kind_next;

    logic signed [SAMPLE_BITS-1:0] samples [CHANNELS];
    logic [3:0]                    ch_sel;
    logic signed [SAMPLE_BITS-1:0] cur;
    logic                          frame_start;
    logic                          accept;
    logic                          pair_ok;
    logic [INDEX_BITS-1:0]         base_count;
    logic                          rise;
    logic                          fall;
    logic                          in_range;
    logic                          mode_ok;
    logic                          hit;
    logic [1:0]                    kind;
    logic signed [SAMPLE_BITS:0]   diff_num;
    logic signed [SAMPLE_BITS:0]   diff_den;
    logic signed [SAMPLE_BITS:0]   mag_num;
    logic signed [SAMPLE_BITS:0]   mag_den;
    logic                          div_start;
    logic                          out_free;
    logic [FRAC_W-1:0]             div_quot;
    div_status_t                   div_status;

    // Unpack the channel samples from the row beat.
    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_unpack
        assign samples[c] = s_tdata[c*SAMPLE_BITS +: SAMPLE_BITS];
    end

    // Pick the examined channel; selections past the last channel use the last one.
    always_comb
    begin
        ch_sel = {2'b00, channel_select_reg};
        if (ch_sel > LAST_CH)
        begin
            ch_sel = LAST_CH;
        end
    end

    assign cur         = samples[ch_sel[CH_IDX_W-1:0]];
    assign frame_start = s_tuser[0];
    assign s_tready    = (state_reg == ST_IDLE);
    assign accept      = s_tvalid && s_tready;
    assign out_free    = !out_valid_reg || m_tready;

    // Classify the pair and test the level against its closed range.
    always_comb
    begin
        pair_ok    = have_prev_reg && !frame_start;
        base_count = frame_start ? '0 : row_count_reg;
        rise       = prev_sample_reg < cur;
        fall       = prev_sample_reg > cur;
        kind       = fall ? KIND_FALL : (rise ? KIND_RISE : KIND_FLAT);
        if (rise)
        begin
            in_range = (trigger_level_reg >= prev_sample_reg) && (trigger_level_reg <= cur);
        end
        else
        begin
            in_range = (trigger_level_reg >= cur) && (trigger_level_reg <= prev_sample_reg);
        end
        mode_ok = (edge_mode_reg == MODE_ANY)
               || ((edge_mode_reg == MODE_RISE) && rise)
               || ((edge_mode_reg == MODE_FALL) && fall);
        hit     = pair_ok && in_range && mode_ok;
    end

    // Magnitudes of level minus first sample and second minus first sample.
    always_comb
    begin
        diff_num = {trigger_level_reg[SAMPLE_BITS-1], trigger_level_reg}
                 - {prev_sample_reg[SAMPLE_BITS-1], prev_sample_reg};
        diff_den = {cur[SAMPLE_BITS-1], cur}
                 - {prev_sample_reg[SAMPLE_BITS-1], prev_sample_reg};
        mag_num  = diff_num[SAMPLE_BITS] ? -diff_num : diff_num;
        mag_den  = diff_den[SAMPLE_BITS] ? -diff_den : diff_den;
    end

    assign div_start = accept && hit && (kind != KIND_FLAT);

    etg_div #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (mag_num[SAMPLE_BITS-1:0]),
        .den    (mag_den[SAMPLE_BITS-1:0]),
        .quot   (div_quot),
        .status (div_status)
    );

    // Controller: frame state update on each row; a hit waits for the fraction if sloped, then goes to the output.
    always_comb
    begin
        state_next       = state_reg;
        prev_sample_next = prev_sample_reg;
        have_prev_next   = have_prev_reg;
        row_count_next   = row_count_reg;
        pend_index_next  = pend_index_reg;
        pend_kind_next   = pend_kind_reg;
        pend_flat_next   = pend_flat_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_index_next   = out_index_reg;
        out_frac_next    = out_frac_reg;
        out_kind_next    = out_kind_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    prev_sample_next = cur;
                    have_prev_next   = 1'b1;
                    row_count_next   = base_count;
                    if (pair_ok && (base_count != INDEX_MAX))
                    begin
                        row_count_next = base_count + 1'b1;
                    end
                    if (hit)
                    begin
                        pend_index_next = base_count;
                        pend_kind_next  = kind;
                        pend_flat_next  = (kind == KIND_FLAT);
                        state_next      = (kind == KIND_FLAT) ? ST_DONE : ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_status.done && !div_status.busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = pend_index_reg;
                    out_frac_next  = pend_flat_reg ? '0 : div_quot;
                    out_kind_next  = pend_kind_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Configuration writes; indexes past the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_level_reg  <= '0;
            edge_mode_reg      <= MODE_ANY;
            channel_select_reg <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_TRIGGER_LEVEL:  trigger_level_reg  <= cfg_data;
                REG_EDGE_MODE:      edge_mode_reg      <= cfg_data[1:0];
                REG_CHANNEL_SELECT: channel_select_reg <= cfg_data[1:0];
                default:            ;
            endcase
        end
    end

    // Control and frame state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            prev_sample_reg <= '0;
            have_prev_reg   <= 1'b0;
            row_count_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            prev_sample_reg <= prev_sample_next;
            have_prev_reg   <= have_prev_next;
            row_count_reg   <= row_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        pend_index_reg <= pend_index_next;
        pend_kind_reg  <= pend_kind_next;
        pend_flat_reg  <= pend_flat_next;
        out_index_reg  <= out_index_next;
        out_frac_reg   <= out_frac_next;
        out_kind_reg   <= out_kind_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({out_frac_reg, out_index_reg});
    assign m_tuser  = out_kind_reg;

endmodule

`default_nettype wire

>>> rtl/etg_checker.sv
// Port-level checks for the edge trigger interpolator and their bind.
`default_nettype none

module etg_checker
    import etg_pkg::*;
#(
    parameter int INDEX_BITS = 16,
    parameter int OUT_W      = 40
)
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [OUT_W-1:0] m_tdata,
    input wire logic [1:0]       m_tuser
);

    logic [FRAC_W-1:0] frac;

    assign frac = m_tdata[INDEX_BITS +: FRAC_W];

    // A stalled result beat holds its contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // The edge kind is always one of the three defined kinds.
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == KIND_FLAT) || (m_tuser == KIND_RISE) || (m_tuser == KIND_FALL))
        else $error("undefined edge kind");

    // A flat pair reports a zero fraction.
    a_flat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_FLAT) |-> (frac == '0))
        else $error("flat pair with nonzero fraction");

    // The fraction never exceeds 1.0.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (frac <= FRAC_W'(1 << FRAC_BITS)))
        else $error("fraction above one");

endmodule

bind edge_trigger_interpolator etg_checker #(
    .INDEX_BITS (INDEX_BITS),
    .OUT_W      (((INDEX_BITS + etg_pkg::FRAC_W + 7) / 8) * 8)
) u_etg_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

>>> dv/tb_edge_trigger_interpolator.sv
// Self-checking testbench for the edge trigger interpolator: directed table, long frame, random phases.
module tb_edge_trigger_interpolator
    import etg_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int S_W    = ((4 * 16 + 7) / 8) * 8;
    localparam int M_W    = ((16 + FRAC_W + 7) / 8) * 8;
    localparam int SETTLE = 30;
    localparam int N_DIR  = 30;

    // Edge mode value that no edge matches.
    localparam logic [1:0] MODE_NONE = 2'd3;

    // One crossing as carried by a master beat.
    typedef struct packed {
        logic [15:0]       index;
        logic [FRAC_W-1:0] frac;
        logic [1:0]        kind;
    } crossing_t;

    // How the expectation of a sample row is obtained.
    typedef enum logic [1:0] {
        CHK_PRED,
        CHK_NONE,
        CHK_GIVEN
    } chk_t;

    // One line of the directed table: a register write or a sample row.
    typedef struct packed {
        bit          is_cfg;
        logic [1:0]  reg_idx;
        logic [15:0] value;
        logic [15:0] other;
        logic        fs;
        chk_t        chk;
        crossing_t   want;
    } dir_row_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_wen = 1'b0;
    logic [1:0]       cfg_index = '0;
    logic [15:0]      cfg_data = '0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [S_W-1:0]   s_tdata = '0;
    logic [0:0]       s_tuser = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [M_W-1:0]   m_tdata;
    logic [1:0]       m_tuser;

    // Side information of the row on the bus, updated together with s_tdata.
    chk_t             row_chk = CHK_PRED;
    crossing_t        row_want = '0;

    // Configuration copy and frame state of the trigger tracker.
    logic signed [15:0] lvl_q = '0;
    logic [1:0]         mode_q = MODE_ANY;
    logic [1:0]         chan_q = '0;
    logic signed [15:0] trk_prev = '0;
    bit                 trk_have = 1'b0;
    logic [15:0]        trk_row = '0;

    crossing_t crossings_due[$];
    int        n_errors = 0;
    int        tx_idle_pct = 0;
    int        rx_stall_pct = 0;
    int        rx_hold_req = 0;

    // Directed rows; channel values are placed on the channel selected at the time.
    dir_row_t dir_rows [N_DIR] = '{
        '{1'b0, REG_TRIGGER_LEVEL, 16'h0000, 16'hFFFF, 1'b1, CHK_NONE, '0},
        '{1'b0, REG_TRIGGER_LEVEL, 16'h0000, 16'h0000, 1'b0, CHK_GIVEN,
          '{16'd0, 17'd0, KIND_FLAT}},
        '{1'b0, REG_TRIGGER_LEVEL, 16'h8000, 16'hFFFF, 1'b0, CHK_GIVEN,
          '{16'd1, 17'd0, KIND_FALL}},
        '{1'b0, REG_TRIGGER_LEVEL, 16'h7FFF, 16'h8000, 1'b0, CHK_PRED, '0},
        '{1'b0, REG_TRIGGER_LEVEL, 16'h7FFF, 16'h0000, 1'b0, CHK_NONE, '0},
        '{1'b0, REG_TRIGGER_LEVEL, 16'h0000, 16'h7FFF, 1'b0, CHK_GIVEN,
          '{16'd4, 17'd65536, KIND_FALL}},
        '{1'b1, REG_EDGE_MODE, {14'b0, MODE_RISE}, 16'h0000, 1'b0, CHK_NONE, '0},
        '{1'b0, REG_TRIGGER_LEVEL, 16'sd10, 16'hA5A5, 1'b1, CHK_NONE, '0},
        '{1'b0, REG_TRIGGER_LEVEL, -16'sd10, 16'h5A5A, 1'b0, CHK_NONE, '0},
        '{1'b0, REG_TRIGGER_LEVEL, 16'sd30, 16'hA5A5, 1'b0, CHK_PRED, '0},
        '{1'b1, REG_EDGE_MODE, {14'b0, MODE_FALL}, 16'h0000, 1'b0, CHK_NONE, '0},
        '{1'b0, REG_TRIGGER_LEVEL, -16'sd1, 16'h0000, 1'b0, CHK_PRED, '0},
        '{1'b0, REG_TRIGGER_LEVEL, 16'sd5, 16'hFFFF, 1'b0, CHK_NONE, '0},
        '{1'b1, REG_EDGE_MODE, {14'b0, MODE_NONE}, 16'h0000, 1'b0, CHK_NONE, '0},
        '{1'b0, REG_TRIGGER_LEVEL, 16'h0000, 16'h1234, 1'b0, CHK_NONE, '0},
        '{1'b0, REG_TRIGGER_LEVEL, 16'h0000, 16'hEDCB, 1'b0, CHK_NONE, '0},
        '{1'b1, REG_EDGE_MODE, {14'b0, MODE_ANY}, 16'h0000, 1'b0, CHK_NONE, '0},
        '{1'b1, REG_TRIGGER_LEVEL, 16'h8000, 16'h0000, 1'b0, CHK_NONE, '0},
        '{1'b1, REG_CHANNEL_SELECT, 16'd3, 16'h0000, 1'b0, CHK_NONE, '0},
        '{1'b0, REG_TRIGGER_LEVEL, 16'h8000, 16'h0000, 1'b1, CHK_NONE, '0},
        '{1'b0, REG_TRIGGER_LEVEL, 16'h8000, 16'h7FFF, 1'b0, CHK_GIVEN,
          '{16'd0, 17'd0, KIND_FLAT}},
        '{1'b0, REG_TRIGGER_LEVEL, 16'h7FFF, 16'h8000, 1'b0, CHK_GIVEN,
          '{16'd1, 17'd0, KIND_RISE}},
        '{1'b0, REG_TRIGGER_LEVEL, 16'h8000, 16'hFFFF, 1'b0, CHK_GIVEN,
          '{16'd2, 17'd65536, KIND_FALL}},
        '{1'b1, REG_TRIGGER_LEVEL, 16'h7FFF, 16'h0000, 1'b0, CHK_NONE, '0},
        '{1'b0, REG_TRIGGER_LEVEL, 16'h7FFF, 16'h0000, 1'b0, CHK_GIVEN,
          '{16'd3, 17'd65536, KIND_RISE}},
        '{1'b0, REG_TRIGGER_LEVEL, 16'h7FFF, 16'h8000, 1'b0, CHK_GIVEN,
          '{16'd4, 17'd0, KIND_FLAT}},
        '{1'b1, REG_CHANNEL_SELECT, 16'd1, 16'h0000, 1'b0, CHK_NONE, '0},
        '{1'b0, REG_TRIGGER_LEVEL, 16'h0000, 16'h7FFF, 1'b0, CHK_PRED, '0},
        '{1'b0, REG_TRIGGER_LEVEL, 16'sd100, 16'h8000, 1'b1, CHK_NONE, '0},
        '{1'b0, REG_TRIGGER_LEVEL, 16'h7FFF, 16'h0000, 1'b0, CHK_PRED, '0}
    };

    edge_trigger_interpolator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // from bit 0 up: sample_ch0, sample_ch1, sample_ch2, sample_ch3
        .s_tuser   (s_tuser),   // bit 0: frame_start
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // from bit 0 up: crossing_index, crossing_fraction, zero padding
        .m_tuser   (m_tuser)    // edge_kind
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Run limit, far above the slowest correct run.
    initial
    begin
        #(25_000_000);
        $display("tb: failure");
        $finish;
    end

    // Advances the trigger tracker by one row and tells whether it reports a crossing.
    function automatic bit track_row(input logic [S_W-1:0] row, input logic fs,
                                     output crossing_t c);
        logic signed [15:0] cur;
        logic [1:0]         kind;
        longint             s1, s2, lv, num, den, q;
        bit                 hit;
        bit                 match;
        cur = row[int'(chan_q) * 16 +: 16];
        hit = 1'b0;
        c = '0;
        if (fs)
        begin
            trk_have = 1'b0;
            trk_row = '0;
        end
        if (trk_have)
        begin
            s1 = trk_prev;
            s2 = cur;
            lv = lvl_q;
            kind = (s1 > s2) ? KIND_FALL : ((s1 < s2) ? KIND_RISE : KIND_FLAT);
            match = (mode_q == MODE_ANY) || (mode_q == MODE_RISE && kind == KIND_RISE)
                    || (mode_q == MODE_FALL && kind == KIND_FALL);
            if (lv >= ((s1 < s2) ? s1 : s2) && lv <= ((s1 < s2) ? s2 : s1) && match)
            begin
                hit = 1'b1;
                c.index = trk_row;
                c.kind = kind;
                // A flat pair reports position zero; a slope is interpolated and truncated.
                if (kind != KIND_FLAT)
                begin
                    num = ((lv >= s1) ? lv - s1 : s1 - lv) * 65536;
                    den = (s2 >= s1) ? s2 - s1 : s1 - s2;
                    q = num / den;
                    if (q > 65536)
                        q = 65536;
                    c.frac = q[FRAC_W-1:0];
                end
            end
            // The frame index sticks at its maximum in very long frames.
            if (trk_row != 16'hFFFF)
                trk_row = trk_row + 16'd1;
        end
        trk_prev = cur;
        trk_have = 1'b1;
        return hit;
    endfunction

    // Puts a sample on the selected channel of an otherwise given row.
    function automatic logic [S_W-1:0] place_sample(input logic [S_W-1:0] base,
                                                    input logic [15:0] smp);
        logic [S_W-1:0] r;
        r = base;
        r[int'(chan_q) * 16 +: 16] = smp;
        return r;
    endfunction

    // Picks the next watched sample, biased toward crossings of the trigger level.
    function automatic logic [15:0] next_sample(input logic signed [15:0] prev);
        int v;
        int r;
        r = $urandom_range(99);
        if (r < 25)
            v = int'($urandom_range(65535)) - 32768;
        else if (r < 55)
            v = int'(lvl_q) + int'($urandom_range(600)) - 300;
        else if (r < 65)
            v = int'(lvl_q);
        else if (r < 75)
            v = int'(prev);
        else if (r < 85)
            v = 2 * int'(lvl_q) - int'(prev);
        else
            v = ($urandom_range(1) == 0) ? 32767 : -32768;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    // Check of master beats and tracking of slave beats and register writes.
    always @(posedge clk)
    begin : scoreboard
        crossing_t got;
        crossing_t want;
        crossing_t pred;
        bit        hit;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.index = m_tdata[15:0];
                got.frac  = m_tdata[16 +: FRAC_W];
                got.kind  = m_tuser;
                if (crossings_due.size() == 0)
                begin
                    $error("unexpected crossing beat: index %0d fraction %0d kind %0d",
                           got.index, got.frac, got.kind);
                    n_errors++;
                end
                else
                begin
                    want = crossings_due.pop_front();
                    if (got.index !== want.index)
                    begin
                        $error("crossing_index: expected %0d, got %0d", want.index, got.index);
                        n_errors++;
                    end
                    if (got.frac !== want.frac)
                    begin
                        $error("crossing_fraction: expected %0d, got %0d", want.frac, got.frac);
                        n_errors++;
                    end
                    if (got.kind !== want.kind)
                    begin
                        $error("edge_kind: expected %0d, got %0d", want.kind, got.kind);
                        n_errors++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                hit = track_row(s_tdata, s_tuser[0], pred);
                if (row_chk == CHK_GIVEN)
                    crossings_due.push_back(row_want);
                else if (row_chk == CHK_PRED && hit)
                    crossings_due.push_back(pred);
            end
            if (cfg_wen)
            begin
                case (cfg_index)
                    REG_TRIGGER_LEVEL:  lvl_q = cfg_data;
                    REG_EDGE_MODE:      mode_q = cfg_data[1:0];
                    REG_CHANNEL_SELECT: chan_q = cfg_data[1:0];
                    default: ;
                endcase
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    initial
    begin : rx_drive
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_req > 0)
            begin
                hold_left = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Offers one row until it is taken, then leaves a random gap.
    task automatic send_row(input logic [S_W-1:0] row, input logic fs, input chk_t chk,
                            input crossing_t want, input bit stop_after);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= row;
        s_tuser  <= fs;
        row_chk  <= chk;
        row_want <= want;
        do
            @(posedge clk);
        while (!s_tready);
        gap = 0;
        while (gap < 20 && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (stop_after || gap > 0)
            s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
    endtask

    // Waits until every crossing has come out and the block has settled.
    task automatic wait_drained();
        while (crossings_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        wait_drained();
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        // Wait again so the register copy is current before the next row is built.
        @(posedge clk);
    endtask

    // One random phase under one trigger setting and one idling pattern.
    task automatic run_phase(input int n_items, input int tx_pct, input int rx_pct,
                             input logic [15:0] lvl, input logic [1:0] mode,
                             input logic [1:0] chan, input int hold_at);
        logic [15:0] gen_prev;
        logic [15:0] smp;
        write_reg(REG_TRIGGER_LEVEL, lvl);
        write_reg(REG_EDGE_MODE, {14'b0, mode});
        write_reg(REG_CHANNEL_SELECT, {14'b0, chan});
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        gen_prev = lvl;
        for (int i = 0; i < n_items; i++)
        begin
            if (i == hold_at)
                rx_hold_req = 400;
            smp = next_sample(gen_prev);
            gen_prev = smp;
            send_row(place_sample({$urandom, $urandom}, smp), $urandom_range(19) == 0,
                     CHK_PRED, '0, i == n_items - 1);
        end
    endtask

    initial
    begin : stimulus
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table under default idling.
        for (int i = 0; i < N_DIR; i++)
        begin
            if (dir_rows[i].is_cfg)
                write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
            else
                send_row(place_sample({4{dir_rows[i].other}}, dir_rows[i].value),
                         dir_rows[i].fs, dir_rows[i].chk, dir_rows[i].want,
                         (i == N_DIR - 1) || dir_rows[(i + 1) % N_DIR].is_cfg);
        end

        // A longer frame with a crossing either way late in it.
        write_reg(REG_TRIGGER_LEVEL, 16'd100);
        write_reg(REG_EDGE_MODE, {14'b0, MODE_ANY});
        write_reg(REG_CHANNEL_SELECT, 16'd0);
        send_row(place_sample({$urandom, $urandom}, 16'd0), 1'b1, CHK_NONE, '0, 1'b0);
        repeat (20)
            send_row(place_sample({$urandom, $urandom}, 16'd0), 1'b0, CHK_PRED, '0, 1'b0);
        send_row(place_sample({$urandom, $urandom}, 16'd200), 1'b0, CHK_GIVEN,
                 '{16'd20, 17'd32768, KIND_RISE}, 1'b0);
        send_row(place_sample({$urandom, $urandom}, 16'd0), 1'b0, CHK_GIVEN,
                 '{16'd21, 17'd32768, KIND_FALL}, 1'b0);
        send_row(place_sample({$urandom, $urandom}, 16'd200), 1'b0, CHK_PRED, '0, 1'b1);

        // Random phases across settings and idling patterns.
        run_phase(70, 0, 0, 16'($urandom_range(65535)), MODE_ANY, 2'd2, 10);
        run_phase(70, 0, 0, 16'h8000, MODE_RISE, 2'd3, -1);
        run_phase(70, 56, 0, 16'h7FFF, MODE_FALL, 2'd0, -1);
        run_phase(70, 56, 0, 16'($urandom_range(65535)), MODE_ANY, 2'd1, -1);
        run_phase(30, 0, 56, 16'($urandom_range(65535)), MODE_NONE, 2'd2, -1);
        run_phase(70, 0, 56, 16'($urandom_range(65535)), MODE_ANY,
                  2'($urandom_range(3)), -1);
        run_phase(70, 30, 30, 16'h0000, MODE_ANY, 2'd3, -1);
        run_phase(70, 30, 30, 16'($urandom_range(65535)), 2'($urandom_range(3)),
                  2'($urandom_range(3)), -1);

        wait_drained();
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
